>>> rtl/core/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types and constants for the bracket pair matcher: character codes,
// item classes, result status codes and the front/back queue item.
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;
  localparam int FIELD_W  = 16;

  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [FIELD_W-1:0]  field_t;

  localparam char_t CH_OPEN  = 8'h5B;  // [
  localparam char_t CH_CLOSE = 8'h5D;  // ]
  localparam char_t CH_PLUS  = 8'h2B;  // +
  localparam char_t CH_MINUS = 8'h2D;  // -
  localparam char_t CH_RIGHT = 8'h3E;  // >
  localparam char_t CH_LEFT  = 8'h3C;  // <
  localparam char_t CH_COMMA = 8'h2C;  // ,
  localparam char_t CH_DOT   = 8'h2E;  // .

  localparam status_t ST_IGNORED   = 3'd0;
  localparam status_t ST_PLAIN_OP  = 3'd1;
  localparam status_t ST_PUSHED    = 3'd2;
  localparam status_t ST_MATCHED   = 3'd3;
  localparam status_t ST_UNMATCHED = 3'd4;
  localparam status_t ST_OVERFLOW  = 3'd5;

  typedef enum logic [1:0] {
    CLS_IGNORE,
    CLS_OP,
    CLS_OPEN,
    CLS_CLOSE
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic last;
  } item_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

endpackage

>>> rtl/core/bracket_pair_matcher_unit.sv
// ----------------------------------------------------------------------------
// bracket_pair_matcher_unit
// Counts operator characters and matches brackets on a bounded stack.
// Path: an accepted input is written into a queue slot; the back side pops it
// into the output register once that register is free or not stalled.
// Throughput: one transaction per cycle unless the output stalls; the stack
// RAM prefetches the entry below the top register, so pops need no stall.
// Reset: counters, stack depth, error flag and queue clear; stack RAM contents
// are left as they are.
// ----------------------------------------------------------------------------
module bracket_pair_matcher_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bpm_pkg::char_t   in_character,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_stall,
  output bpm_pkg::status_t out_status,
  output bpm_pkg::field_t  out_op_index,
  output bpm_pkg::field_t  out_bracket_index,
  output bpm_pkg::field_t  out_partner_index,
  output logic             out_error_seen,
  output logic             out_program_done,
  output logic             out_program_ok,
  output bpm_pkg::field_t  out_op_total
);

  import bpm_pkg::*;

  logic  q_full, q_push, q_pop, q_empty;
  item_t push_item, pop_item;

  bpm_front u_front (
    .in_valid     (in_valid),
    .in_character (in_character),
    .in_last      (in_last),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  bpm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  bpm_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_op_index      (out_op_index),
    .out_bracket_index (out_bracket_index),
    .out_partner_index (out_partner_index),
    .out_error_seen    (out_error_seen),
    .out_program_done  (out_program_done),
    .out_program_ok    (out_program_ok),
    .out_op_total      (out_op_total)
  );

endmodule

>>> rtl/core/bpm_ram.sv
// ----------------------------------------------------------------------------
// bpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/bpm_front.sv
// ----------------------------------------------------------------------------
// bpm_front
// Input side: accepts a character transaction, classifies the byte and
// pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module bpm_front (
  input  logic            in_valid,
  input  bpm_pkg::char_t  in_character,
  input  logic            in_last,
  output logic            in_stall,
  input  logic            q_full,
  output logic            q_push,
  output bpm_pkg::item_t  q_item
);

  import bpm_pkg::*;

  cls_t cls;

  always_comb begin
    unique case (in_character) inside
      CH_PLUS, CH_MINUS, CH_RIGHT, CH_LEFT, CH_COMMA, CH_DOT: cls = CLS_OP;
      CH_OPEN:  cls = CLS_OPEN;
      CH_CLOSE: cls = CLS_CLOSE;
      default:  cls = CLS_IGNORE;
    endcase
  end

  assign in_stall    = q_full;
  assign q_push      = in_valid && !q_full;
  assign q_item.cls  = cls;
  assign q_item.last = in_last;

endmodule

>>> rtl/core/bpm_queue.sv
// ----------------------------------------------------------------------------
// bpm_queue
// Short FIFO between the front and back sides.
// ----------------------------------------------------------------------------
module bpm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bpm_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output bpm_pkg::item_t  pop_item,
  output logic            empty
);

  import bpm_pkg::*;

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/core/bpm_back.sv
// ----------------------------------------------------------------------------
// bpm_back
// Execution side: counters, bracket stack and the result output register.
// Top of stack lives in a register; the RAM read port always prefetches the
// entry below the top so a pop never waits on a RAM read.
// ----------------------------------------------------------------------------
module bpm_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  bpm_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output bpm_pkg::status_t out_status,
  output bpm_pkg::field_t  out_op_index,
  output bpm_pkg::field_t  out_bracket_index,
  output bpm_pkg::field_t  out_partner_index,
  output logic             out_error_seen,
  output logic             out_program_done,
  output logic             out_program_ok,
  output bpm_pkg::field_t  out_op_total
);

  import bpm_pkg::*;

  localparam int INDEX_BITS = FIELD_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

  logic [DW-1:0]         depth_r, depth_upd;
  logic [INDEX_BITS-1:0] br_cnt_r, br_upd;
  logic [INDEX_BITS-1:0] op_cnt_r, op_upd;
  logic                  err_r, err_upd;
  logic [INDEX_BITS-1:0] tos_r, tos_upd;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [INDEX_BITS-1:0] rd_data;

  status_t               status;
  logic [INDEX_BITS-1:0] op_idx, br_idx, partner;

  logic                  out_valid_r;
  status_t               status_r;
  field_t                op_index_r, bracket_index_r, partner_index_r, op_total_r;
  logic                  error_seen_r, program_done_r, program_ok_r;

  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    depth_upd = depth_r;
    br_upd    = br_cnt_r;
    op_upd    = op_cnt_r;
    err_upd   = err_r;
    tos_upd   = tos_r;
    wr_en     = 1'b0;
    wr_addr   = depth_r[AW-1:0];
    status    = ST_IGNORED;
    op_idx    = '0;
    br_idx    = '0;
    partner   = '0;
    if (q_pop) begin
      unique case (q_item.cls)
        CLS_OP: status = ST_PLAIN_OP;
        CLS_OPEN: begin
          br_idx = br_cnt_r;
          br_upd = (br_cnt_r == IDX_MAX) ? br_cnt_r : br_cnt_r + INDEX_BITS'(1);
          if (depth_r != DW'(STACK_DEPTH)) begin
            wr_en     = 1'b1;
            tos_upd   = br_cnt_r;
            depth_upd = depth_r + DW'(1);
            status    = ST_PUSHED;
          end else begin
            err_upd = 1'b1;
            status  = ST_OVERFLOW;
          end
        end
        CLS_CLOSE: begin
          br_idx = br_cnt_r;
          br_upd = (br_cnt_r == IDX_MAX) ? br_cnt_r : br_cnt_r + INDEX_BITS'(1);
          if (depth_r != '0) begin
            partner   = tos_r;
            tos_upd   = rd_data;
            depth_upd = depth_r - DW'(1);
            status    = ST_MATCHED;
          end else begin
            err_upd = 1'b1;
            status  = ST_UNMATCHED;
          end
        end
        default: ;
      endcase
      if (q_item.cls != CLS_IGNORE) begin
        op_idx = op_cnt_r;
        op_upd = (op_cnt_r == IDX_MAX) ? op_cnt_r : op_cnt_r + INDEX_BITS'(1);
      end
    end
  end

  // prefetch the entry that sits below the top after this cycle
  assign rd_addr = AW'(depth_upd - DW'(2));

  bpm_ram #(
    .WIDTH (INDEX_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (br_cnt_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      br_cnt_r    <= '0;
      op_cnt_r    <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop && q_item.last) begin
        depth_r  <= '0;
        br_cnt_r <= '0;
        op_cnt_r <= '0;
        err_r    <= 1'b0;
      end else begin
        depth_r  <= depth_upd;
        br_cnt_r <= br_upd;
        op_cnt_r <= op_upd;
        err_r    <= err_upd;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_upd;
    if (q_pop) begin
      status_r        <= status;
      op_index_r      <= FIELD_W'(op_idx);
      bracket_index_r <= FIELD_W'(br_idx);
      partner_index_r <= FIELD_W'(partner);
      error_seen_r    <= err_upd;
      program_done_r  <= q_item.last;
      program_ok_r    <= q_item.last && !err_upd && (depth_upd == '0);
      op_total_r      <= FIELD_W'(op_upd);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_op_index      = op_index_r;
  assign out_bracket_index = bracket_index_r;
  assign out_partner_index = partner_index_r;
  assign out_error_seen    = error_seen_r;
  assign out_program_done  = program_done_r;
  assign out_program_ok    = program_ok_r;
  assign out_op_total      = op_total_r;

endmodule

>>> tb/sv/bracket_pair_matcher_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bracket_pair_matcher_unit_test
// Self-checking bench for the bracket pair matcher. Programs are streamed in
// one character per transaction. An in-bench predictor tracks the operator
// and bracket counters, the open stack and the sticky error, and every result
// transaction is compared field by field. Directed tests cover operators,
// nesting, unmatched closes, stack limits and back-pressure. Random programs,
// mostly well-formed, run under several idle/stall mixes.
// ----------------------------------------------------------------------------
module bracket_pair_matcher_unit_test;
  import bpm_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_OPS  = 1080;

  typedef struct packed {
    status_t status;
    field_t  op_index;
    field_t  bracket_index;
    field_t  partner_index;
    logic    error_seen;
    logic    program_done;
    logic    program_ok;
    field_t  op_total;
  } match_result_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  char_t   in_character = '0;
  logic    in_last = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  status_t out_status;
  field_t  out_op_index;
  field_t  out_bracket_index;
  field_t  out_partner_index;
  logic    out_error_seen;
  logic    out_program_done;
  logic    out_program_ok;
  field_t  out_op_total;

  bracket_pair_matcher_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_character     (in_character),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_op_index     (out_op_index),
    .out_bracket_index(out_bracket_index),
    .out_partner_index(out_partner_index),
    .out_error_seen   (out_error_seen),
    .out_program_done (out_program_done),
    .out_program_ok   (out_program_ok),
    .out_op_total     (out_op_total)
  );

  always #1 clk = ~clk;

  // predictor state
  field_t open_stack_m [STACK_DEPTH];
  int     depth_m;
  field_t bracket_cnt;
  field_t op_cnt;
  logic   err_m;

  match_result_t pending_matches[$];
  match_result_t want_r;

  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int sent_count = 0;
  int checked_count = 0;
  int program_count = 0;
  int random_ops = 0;
  int status_hits [6];

  char_t op_chars [8] = '{CH_PLUS, CH_MINUS, CH_RIGHT, CH_LEFT,
                          CH_COMMA, CH_DOT, CH_OPEN, CH_CLOSE};

  function automatic field_t sat_inc(field_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_matcher_state();
    depth_m     = 0;
    bracket_cnt = '0;
    op_cnt      = '0;
    err_m       = 1'b0;
  endfunction

  function automatic match_result_t predict_match(char_t c, logic l);
    match_result_t r;
    logic is_op;
    r = '0;
    is_op = 1'b0;
    case (c)
      CH_PLUS, CH_MINUS, CH_RIGHT, CH_LEFT, CH_COMMA, CH_DOT: begin
        is_op = 1'b1;
        r.status = ST_PLAIN_OP;
      end
      CH_OPEN: begin
        is_op = 1'b1;
        r.bracket_index = bracket_cnt;
        bracket_cnt = sat_inc(bracket_cnt);
        if (depth_m < STACK_DEPTH) begin
          open_stack_m[depth_m] = r.bracket_index;
          depth_m++;
          r.status = ST_PUSHED;
        end else begin
          err_m = 1'b1;
          r.status = ST_OVERFLOW;
        end
      end
      CH_CLOSE: begin
        is_op = 1'b1;
        r.bracket_index = bracket_cnt;
        bracket_cnt = sat_inc(bracket_cnt);
        if (depth_m > 0) begin
          depth_m--;
          r.partner_index = open_stack_m[depth_m];
          r.status = ST_MATCHED;
        end else begin
          err_m = 1'b1;
          r.status = ST_UNMATCHED;
        end
      end
      default: ;
    endcase
    if (is_op) begin
      r.op_index = op_cnt;
      op_cnt = sat_inc(op_cnt);
    end
    r.error_seen   = err_m;
    r.program_done = l;
    r.program_ok   = l && !err_m && (depth_m == 0);
    r.op_total     = op_cnt;
    if (l) clear_matcher_state();
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        $error("result transaction with nothing pending");
        errors++;
      end else begin
        want_r = pending_matches.pop_front();
        compare_field("status", want_r.status, out_status);
        compare_field("op_index", want_r.op_index, out_op_index);
        compare_field("bracket_index", want_r.bracket_index, out_bracket_index);
        compare_field("partner_index", want_r.partner_index, out_partner_index);
        compare_field("error_seen", want_r.error_seen, out_error_seen);
        compare_field("program_done", want_r.program_done, out_program_done);
        compare_field("program_ok", want_r.program_ok, out_program_ok);
        compare_field("op_total", want_r.op_total, out_op_total);
        checked_count++;
      end
    end
  end

  // receiver stall, with long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_char(char_t c, logic l);
    match_result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= c;
    in_last      <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_match(c, l);
    pending_matches.push_back(r);
    status_hits[r.status]++;
    sent_count++;
    random_ops++;
    if (l) program_count++;
  endtask

  task automatic send_program(ref char_t prog[$]);
    for (int i = 0; i < prog.size(); i++) send_char(prog[i], i == prog.size() - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic char_t filler_char();
    char_t c;
    if ($urandom_range(0, 99) < 60) return op_chars[$urandom_range(0, 5)];
    c = char_t'($urandom_range(0, 255));
    if (c == CH_OPEN || c == CH_CLOSE) c = CH_PLUS;
    return c;
  endfunction

  function automatic char_t any_char();
    if ($urandom_range(0, 1)) return char_t'($urandom_range(0, 255));
    return op_chars[$urandom_range(0, 7)];
  endfunction

  task automatic test_operators();
    char_t prog[$];
    prog = '{CH_PLUS, CH_MINUS, CH_RIGHT, CH_LEFT, CH_COMMA, 8'h00, 8'hFF,
             8'h80, 8'h7F, CH_DOT};
    send_program(prog);
    wait_idle();
  endtask

  task automatic test_nested_pairs();
    char_t prog[$];
    prog = '{CH_OPEN, CH_PLUS, CH_OPEN, CH_MINUS, CH_CLOSE, CH_RIGHT,
             CH_CLOSE, CH_LEFT};
    send_program(prog);
    wait_idle();
  endtask

  task automatic test_unmatched_close();
    char_t prog[$];
    prog = '{CH_CLOSE, CH_OPEN, CH_CLOSE, CH_COMMA};
    send_program(prog);
    prog = '{CH_OPEN, CH_CLOSE, 8'h41};
    send_program(prog);
    wait_idle();
  endtask

  task automatic test_stack_limits();
    char_t prog[$];
    prog = {};
    repeat (STACK_DEPTH) prog.push_back(CH_OPEN);
    repeat (STACK_DEPTH) prog.push_back(CH_CLOSE);
    send_program(prog);
    prog = {};
    repeat (STACK_DEPTH + 1) prog.push_back(CH_OPEN);
    repeat (STACK_DEPTH) prog.push_back(CH_CLOSE);
    prog.push_back(CH_DOT);
    send_program(prog);
    wait_idle();
  endtask

  task automatic test_backpressure();
    char_t prog[$];
    prog = {};
    for (int i = 0; i < 24; i++) prog.push_back(i % 3 == 0 ? CH_OPEN : filler_char());
    repeat (8) prog.push_back(CH_CLOSE);
    @(negedge clk);
    hold_cycles = 60;
    @(posedge clk);
    send_program(prog);
    wait_idle();
  endtask

  task automatic send_random_program();
    char_t prog[$];
    int kind, len, depth, maxd, r;
    prog = {};
    depth = 0;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      maxd = ($urandom_range(0, 9) == 0) ? STACK_DEPTH : $urandom_range(1, 8);
      if (maxd == STACK_DEPTH) begin
        repeat (STACK_DEPTH) begin
          prog.push_back(CH_OPEN);
          if ($urandom_range(0, 3) == 0) prog.push_back(filler_char());
        end
        depth = STACK_DEPTH;
      end
      len = $urandom_range(1, 30);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 30 && depth < maxd) begin
          prog.push_back(CH_OPEN);
          depth++;
        end else if (r < 55 && depth > 0) begin
          prog.push_back(CH_CLOSE);
          depth--;
        end else begin
          prog.push_back(filler_char());
        end
      end
      repeat (depth) prog.push_back(CH_CLOSE);
      if ($urandom_range(0, 3) == 0) prog.push_back(filler_char());
    end else if (kind < 85) begin
      len = $urandom_range(1, 20);
      repeat (len) prog.push_back(any_char());
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          repeat ($urandom_range(0, 5)) prog.push_back(filler_char());
          prog.push_back(CH_CLOSE);
          repeat ($urandom_range(0, 5)) prog.push_back(any_char());
        end
        1: begin
          repeat (STACK_DEPTH + $urandom_range(1, 3)) prog.push_back(CH_OPEN);
          repeat ($urandom_range(0, 6)) prog.push_back(any_char());
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            prog.push_back(CH_OPEN);
            prog.push_back(filler_char());
          end
        end
      endcase
    end
    send_program(prog);
  endtask

  task automatic test_random_programs();
    int idle_mix [4] = '{0, 66, 0, 20};
    int stall_mix [4] = '{0, 0, 66, 20};
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_mix[p];
      stall_pct = stall_mix[p];
      while (random_ops < (p + 1) * RANDOM_OPS / 4) send_random_program();
      wait_idle();
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    clear_matcher_state();
    foreach (status_hits[i]) status_hits[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_operators();
    test_nested_pairs();
    test_unmatched_close();
    test_stack_limits();
    test_backpressure();
    random_ops = 0;
    test_random_programs();

    wait_idle();
    $display("checked %0d of %0d transactions over %0d programs", checked_count,
             sent_count, program_count);
    $display("pushes %0d, matches %0d, unmatched closes %0d, overflows %0d",
             status_hits[ST_PUSHED], status_hits[ST_MATCHED],
             status_hits[ST_UNMATCHED], status_hits[ST_OVERFLOW]);
    if (errors == 0 && pending_matches.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bpm_pkg.sv
rtl/core/bpm_ram.sv
rtl/core/bpm_front.sv
rtl/core/bpm_queue.sv
rtl/core/bpm_back.sv
rtl/core/bracket_pair_matcher_unit.sv
tb/sv/bracket_pair_matcher_unit_test.sv
